[design/qvr_pkg.sv]
// Package for the quaternion vector rotation block: widths, payload types, clamp limits.
package qvr_pkg;

   // Field widths at the ports
   localparam int QW = 32;               // quaternion part, Q2.30
   localparam int VW = 32;               // vector part, Q16.16
   localparam int OW = 32;               // rotated component, Q16.16

   // First product q*v is exact in QW+VW bits; sum of three needs two more
   localparam int PW = QW + VW;
   localparam int TW = PW + 2;

   // Second product t*q is split at LOSPLIT bits of t: low half unsigned, high half signed
   localparam int LOSPLIT = 33;
   localparam int PLW     = LOSPLIT + 1 + QW;
   localparam int PHW     = TW - LOSPLIT + QW;

   // Exact width of a vector component of r, and the Q76 to Q16 shift
   localparam int RW    = TW + QW + 2;
   localparam int SHIFT = 60;

   // Number of t*q products for the three vector components
   localparam int NPROD = 12;

   localparam logic signed [OW-1:0] SAT_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [OW-1:0] SAT_MIN = {1'b1, {(OW-1){1'b0}}};

   typedef struct packed {
      logic signed [QW-1:0] w;
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
   } vec_type;

   typedef struct packed {
      quat_type quat;
      vec_type  vec;
   } req_type;

   // t = q * (0, v), exact
   typedef struct packed {
      logic signed [TW-1:0] w;
      logic signed [TW-1:0] x;
      logic signed [TW-1:0] y;
      logic signed [TW-1:0] z;
   } tquat_type;

   typedef struct packed {
      tquat_type t;
      quat_type  q;
   } ham_type;

   // Vector part of r = t * conj(q), exact
   typedef struct packed {
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [RW-1:0] z;
   } rvec_type;

   typedef struct packed {
      logic signed [OW-1:0] rot_x;
      logic signed [OW-1:0] rot_y;
      logic signed [OW-1:0] rot_z;
      logic                 saturated;
   } rsp_type;

endpackage

[design/qvr_if.sv]
// Valid/ready channel interfaces for the request and response items.
interface qvr_req_if;
   import qvr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [QW-1:0] quat_w;
   logic signed [QW-1:0] quat_x;
   logic signed [QW-1:0] quat_y;
   logic signed [QW-1:0] quat_z;
   logic signed [VW-1:0] vec_x;
   logic signed [VW-1:0] vec_y;
   logic signed [VW-1:0] vec_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
                   output ready);
   modport monitor (input valid, ready, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z);
endinterface

interface qvr_rsp_if;
   import qvr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [OW-1:0] rot_x;
   logic signed [OW-1:0] rot_y;
   logic signed [OW-1:0] rot_z;
   logic                 saturated;

   modport source (output valid, rot_x, rot_y, rot_z, saturated, input ready);
   modport sink   (input valid, rot_x, rot_y, rot_z, saturated, output ready);
   modport monitor (input valid, ready, rot_x, rot_y, rot_z, saturated);
endinterface

[design/qvr_hamilton.sv]
// Two pipeline stages: the twelve q*v products, then t = q * (0, v).
module qvr_hamilton
   import qvr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output ham_type out_data
);

   logic                 prod_v_ff;
   logic signed [PW-1:0] prod_ff [NPROD];
   logic signed [PW-1:0] prod_in [NPROD];
   quat_type             prod_q_ff;
   logic                 ham_v_ff;
   ham_type              ham_ff;
   ham_type              ham_in;
   logic                 prod_en;
   logic                 ham_en;

   // A stage loads when it is empty or its contents move on
   assign ham_en   = !ham_v_ff || out_ready;
   assign prod_en  = !prod_v_ff || ham_en;
   assign in_ready = prod_en;

   // Stage 1: products, order xvx yvy zvz wvx yvz zvy wvy xvz zvx wvz xvy yvx
   always_comb begin
      prod_in[0]  = PW'(in_data.quat.x) * PW'(in_data.vec.x);
      prod_in[1]  = PW'(in_data.quat.y) * PW'(in_data.vec.y);
      prod_in[2]  = PW'(in_data.quat.z) * PW'(in_data.vec.z);
      prod_in[3]  = PW'(in_data.quat.w) * PW'(in_data.vec.x);
      prod_in[4]  = PW'(in_data.quat.y) * PW'(in_data.vec.z);
      prod_in[5]  = PW'(in_data.quat.z) * PW'(in_data.vec.y);
      prod_in[6]  = PW'(in_data.quat.w) * PW'(in_data.vec.y);
      prod_in[7]  = PW'(in_data.quat.x) * PW'(in_data.vec.z);
      prod_in[8]  = PW'(in_data.quat.z) * PW'(in_data.vec.x);
      prod_in[9]  = PW'(in_data.quat.w) * PW'(in_data.vec.z);
      prod_in[10] = PW'(in_data.quat.x) * PW'(in_data.vec.y);
      prod_in[11] = PW'(in_data.quat.y) * PW'(in_data.vec.x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else if (prod_en) begin
         prod_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_en) begin
         prod_ff   <= prod_in;
         prod_q_ff <= in_data.quat;
      end
   end

   // Stage 2: sums of three products per component of t
   always_comb begin
      ham_in.t.w = -TW'(prod_ff[0]) - TW'(prod_ff[1]) - TW'(prod_ff[2]);
      ham_in.t.x =  TW'(prod_ff[3]) + TW'(prod_ff[4]) - TW'(prod_ff[5]);
      ham_in.t.y =  TW'(prod_ff[6]) - TW'(prod_ff[7]) + TW'(prod_ff[8]);
      ham_in.t.z =  TW'(prod_ff[9]) + TW'(prod_ff[10]) - TW'(prod_ff[11]);
      ham_in.q   = prod_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ham_v_ff <= 1'b0;
      end else if (ham_en) begin
         ham_v_ff <= prod_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ham_en) begin
         ham_ff <= ham_in;
      end
   end

   assign out_valid = ham_v_ff;
   assign out_data  = ham_ff;

endmodule

[design/qvr_conj_mul.sv]
// Three pipeline stages: split t*q partial products, full products, vector part of t*conj(q).
module qvr_conj_mul
   import qvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  ham_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rvec_type out_data
);

   logic signed [TW-1:0]  tsel [NPROD];
   logic signed [QW-1:0]  qsel [NPROD];
   logic signed [PLW-1:0] plo_in [NPROD];
   logic signed [PHW-1:0] phi_in [NPROD];
   logic signed [PLW-1:0] plo_ff [NPROD];
   logic signed [PHW-1:0] phi_ff [NPROD];
   logic signed [RW-1:0]  full_in [NPROD];
   logic signed [RW-1:0]  full_ff [NPROD];
   rvec_type              r_in;
   rvec_type              r_ff;
   logic                  part_v_ff;
   logic                  full_v_ff;
   logic                  r_v_ff;
   logic                  part_en;
   logic                  full_en;
   logic                  r_en;

   assign r_en     = !r_v_ff || out_ready;
   assign full_en  = !full_v_ff || r_en;
   assign part_en  = !part_v_ff || full_en;
   assign in_ready = part_en;

   // Operand pairs: x row tx.w tw.x ty.z tz.y, y row ty.w tw.y tx.z tz.x, z row tz.w tw.z tx.y ty.x
   always_comb begin
      tsel[0]  = in_data.t.x;  qsel[0]  = in_data.q.w;
      tsel[1]  = in_data.t.w;  qsel[1]  = in_data.q.x;
      tsel[2]  = in_data.t.y;  qsel[2]  = in_data.q.z;
      tsel[3]  = in_data.t.z;  qsel[3]  = in_data.q.y;
      tsel[4]  = in_data.t.y;  qsel[4]  = in_data.q.w;
      tsel[5]  = in_data.t.w;  qsel[5]  = in_data.q.y;
      tsel[6]  = in_data.t.x;  qsel[6]  = in_data.q.z;
      tsel[7]  = in_data.t.z;  qsel[7]  = in_data.q.x;
      tsel[8]  = in_data.t.z;  qsel[8]  = in_data.q.w;
      tsel[9]  = in_data.t.w;  qsel[9]  = in_data.q.z;
      tsel[10] = in_data.t.x;  qsel[10] = in_data.q.y;
      tsel[11] = in_data.t.y;  qsel[11] = in_data.q.x;
   end

   // Stage 3: each wide product as two narrower ones (low half of t unsigned)
   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         plo_in[i] = PLW'($signed({1'b0, tsel[i][LOSPLIT-1:0]})) * PLW'(qsel[i]);
         phi_in[i] = PHW'($signed(tsel[i][TW-1:LOSPLIT])) * PHW'(qsel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_v_ff <= 1'b0;
      end else if (part_en) begin
         part_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (part_en) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
   end

   // Stage 4: recombine halves
   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         full_in[i] = (RW'(phi_ff[i]) <<< LOSPLIT) + RW'(plo_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_v_ff <= 1'b0;
      end else if (full_en) begin
         full_v_ff <= part_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (full_en) begin
         full_ff <= full_in;
      end
   end

   // Stage 5: signed sums per component, signs from conj(q)
   always_comb begin
      r_in.x = full_ff[0] - full_ff[1] - full_ff[2]  + full_ff[3];
      r_in.y = full_ff[4] - full_ff[5] + full_ff[6]  - full_ff[7];
      r_in.z = full_ff[8] - full_ff[9] - full_ff[10] + full_ff[11];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else if (r_en) begin
         r_v_ff <= full_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r_en) begin
         r_ff <= r_in;
      end
   end

   assign out_valid = r_v_ff;
   assign out_data  = r_ff;

endmodule

[design/qvr_sat.sv]
// Output stage: floor to Q16.16, clamp to 32 bits, flag clipping, output register.
module qvr_sat
   import qvr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  rvec_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   logic    out_v_ff;
   rsp_type out_ff;
   rsp_type out_in;
   logic    clip_x;
   logic    clip_y;
   logic    clip_z;
   logic    out_en;

   assign out_en   = !out_v_ff || out_ready;
   assign in_ready = out_en;

   // Shifted value fits when every bit above the output sign bit matches it
   function automatic logic signed [OW-1:0] clamp(input logic signed [RW-1:0] r);
      logic [RW-SHIFT-OW:0] top;
      top = r[RW-1:SHIFT+OW-1];
      if ((&top) || !(|top)) begin
         return r[SHIFT+OW-1:SHIFT];
      end
      return r[RW-1] ? SAT_MIN : SAT_MAX;
   endfunction

   function automatic logic clipped(input logic signed [RW-1:0] r);
      logic [RW-SHIFT-OW:0] top;
      top = r[RW-1:SHIFT+OW-1];
      return !((&top) || !(|top));
   endfunction

   always_comb begin
      clip_x           = clipped(in_data.x);
      clip_y           = clipped(in_data.y);
      clip_z           = clipped(in_data.z);
      out_in.rot_x     = clamp(in_data.x);
      out_in.rot_y     = clamp(in_data.y);
      out_in.rot_z     = clamp(in_data.z);
      out_in.saturated = clip_x || clip_y || clip_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

endmodule

[design/quaternion_vector_rotate.sv]
// Six register stages; throughput is one item per cycle while rsp_ch is not stalled.
// The twelve 32x32 products of stage 1 and the twenty-four split products of stage 3
// are each fully parallel, so nothing is shared.
// Stalls back up stage by stage; empty stages keep filling while a result waits.
// Reset (synchronous, active high) clears every stage's valid bit; data is not reset.
// Top level of the quaternion vector rotation pipeline.
module quaternion_vector_rotate
   import qvr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   qvr_req_if.sink   req_ch,
   qvr_rsp_if.source rsp_ch
);

   req_type  req_data;
   ham_type  ham_data;
   logic     ham_valid;
   logic     ham_ready;
   rvec_type r_data;
   logic     r_valid;
   logic     r_ready;
   rsp_type  rsp_data;

   always_comb begin
      req_data.quat.w = req_ch.quat_w;
      req_data.quat.x = req_ch.quat_x;
      req_data.quat.y = req_ch.quat_y;
      req_data.quat.z = req_ch.quat_z;
      req_data.vec.x  = req_ch.vec_x;
      req_data.vec.y  = req_ch.vec_y;
      req_data.vec.z  = req_ch.vec_z;
   end

   qvr_hamilton u_hamilton (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_data),
      .out_valid (ham_valid),
      .out_ready (ham_ready),
      .out_data  (ham_data)
   );

   qvr_conj_mul u_conj_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ham_valid),
      .in_ready  (ham_ready),
      .in_data   (ham_data),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_data  (r_data)
   );

   qvr_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid),
      .in_ready  (r_ready),
      .in_data   (r_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.rot_x     = rsp_data.rot_x;
   assign rsp_ch.rot_y     = rsp_data.rot_y;
   assign rsp_ch.rot_z     = rsp_data.rot_z;
   assign rsp_ch.saturated = rsp_data.saturated;

endmodule

[design/qvr_checker.sv]
// Port-level checks for the rotation block, bound to the top level.
module qvr_checker
   import qvr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   qvr_req_if.sink   req_ch,
   qvr_rsp_if.source rsp_ch
);

   // A stalled result item holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.rot_x)
         && $stable(rsp_ch.rot_y) && $stable(rsp_ch.rot_z) && $stable(rsp_ch.saturated))
      else $error("result item changed while stalled");

   // Clipping flag implies at least one component sits at a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.saturated |->
         rsp_ch.rot_x == SAT_MAX || rsp_ch.rot_x == SAT_MIN ||
         rsp_ch.rot_y == SAT_MAX || rsp_ch.rot_y == SAT_MIN ||
         rsp_ch.rot_z == SAT_MAX || rsp_ch.rot_z == SAT_MIN)
      else $error("saturated flag without a clamped component");

   // Pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid right after reset");

   // A draining output lets every stage advance, so the input side is ready
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("input stalled while output is taking items");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch)
);

[bench/quaternion_vector_rotate_test.sv]
// Self-checking testbench for the quaternion vector rotation pipeline.
module quaternion_vector_rotate_test
   import qvr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT    = 2000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 16;
   localparam int N_DIRECTED     = 16;

   localparam logic signed [127:0] Q16_MAX = 128'sd2147483647;
   localparam logic signed [127:0] Q16_MIN = -128'sd2147483648;

   typedef struct packed {
      quat_type quat;
      vec_type  vec;
      logic     typed;   // want holds a hand-worked result
      rsp_type  want;
   } stim_row_type;

   logic clock;
   logic reset;

   qvr_req_if req_ch ();
   qvr_rsp_if rsp_ch ();

   quaternion_vector_rotate dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rsp_type pending_rotations [$];
   int      error_count = 0;
   int      rotations_checked = 0;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;
   bit      holdoff_wanted = 1'b0;

   // Corners first, then hand-worked rotations, then rows left to the predictor
   stim_row_type directed_rows [N_DIRECTED] = '{
      // zero quaternion wipes the vector
      '{'{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h7FFFFFFF, 32'h80000000, 32'h12345678},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
      '{'{32'h0, 32'h0, 32'h0, 32'h0}, '{32'h0, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
      // identity passes the vector through, extremes included
      '{'{32'h40000000, 32'h0, 32'h0, 32'h0}, '{32'h7FFFFFFF, 32'h80000000, 32'h00010000},
        1'b1, '{32'h7FFFFFFF, 32'h80000000, 32'h00010000, 1'b0}},
      // w = -2.0 scales by four
      '{'{32'h80000000, 32'h0, 32'h0, 32'h0}, '{32'h1, 32'hFFFFFFFF, 32'h0},
        1'b1, '{32'h4, 32'hFFFFFFFC, 32'h0, 1'b0}},
      '{'{32'h80000000, 32'h0, 32'h0, 32'h0}, '{32'h7FFFFFFF, 32'h80000000, 32'h0},
        1'b1, '{32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1}},
      // half turn about x; negating -2^31 clips high
      '{'{32'h0, 32'h40000000, 32'h0, 32'h0}, '{32'h00010000, 32'h80000000, 32'h00020000},
        1'b1, '{32'h00010000, 32'h7FFFFFFF, 32'hFFFE0000, 1'b1}},
      // half turns about y and z
      '{'{32'h0, 32'h0, 32'h40000000, 32'h0}, '{32'h1, 32'h2, 32'h3},
        1'b1, '{32'hFFFFFFFF, 32'h2, 32'hFFFFFFFD, 1'b0}},
      '{'{32'h0, 32'h0, 32'h0, 32'h40000000}, '{32'h1, 32'h2, 32'h3},
        1'b1, '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'h3, 1'b0}},
      // tiny quaternion: truncation floors toward minus infinity
      '{'{32'h1, 32'h0, 32'h0, 32'h0}, '{32'h1, 32'hFFFFFFFF, 32'h0},
        1'b1, '{32'h0, 32'hFFFFFFFF, 32'h0, 1'b0}},
      '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '0},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
        '{32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, '0},
      '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, '0},
      '{'{32'h40000000, 32'h0, 32'h0, 32'h40000000}, '{32'h00010000, 32'h00020000, 32'h00030000},
        1'b0, '0},
      '{'{32'h2D413CCD, 32'h2D413CCD, 32'h0, 32'h0}, '{32'h00010000, 32'h00010000, 32'h00010000},
        1'b0, '0},
      '{'{32'h0, 32'h80000000, 32'h0, 32'h0}, '{32'h00000100, 32'h00000200, 32'h00000300},
        1'b0, '0},
      '{'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
        '{32'hFFFFFFFF, 32'h00000001, 32'h80000000}, 1'b0, '0}
   };

   // Q76 component to Q16.16: floor shift, then clip to 32 bits
   function automatic logic signed [OW-1:0] clip_to_q16(input logic signed [127:0] exact,
                                                        inout logic clipped);
      logic signed [127:0] shifted;
      shifted = exact >>> SHIFT;
      if (shifted > Q16_MAX) begin
         clipped = 1'b1;
         return SAT_MAX;
      end
      if (shifted < Q16_MIN) begin
         clipped = 1'b1;
         return SAT_MIN;
      end
      return shifted[OW-1:0];
   endfunction

   // r = q * (0, v) * conj(q), vector part, all in exact 128-bit arithmetic
   function automatic rsp_type rotate_by_quaternion(input quat_type q, input vec_type v);
      logic signed [127:0] qw, qx, qy, qz, vx, vy, vz;
      logic signed [127:0] tw, tx, ty, tz;
      logic                clipped;
      rsp_type             rot;
      qw = $signed(q.w);
      qx = $signed(q.x);
      qy = $signed(q.y);
      qz = $signed(q.z);
      vx = $signed(v.x);
      vy = $signed(v.y);
      vz = $signed(v.z);
      tw = -(qx * vx) - qy * vy - qz * vz;
      tx = qw * vx + qy * vz - qz * vy;
      ty = qw * vy - qx * vz + qz * vx;
      tz = qw * vz + qx * vy - qy * vx;
      clipped   = 1'b0;
      rot.rot_x = clip_to_q16(tx * qw - tw * qx - ty * qz + tz * qy, clipped);
      rot.rot_y = clip_to_q16(ty * qw - tw * qy + tx * qz - tz * qx, clipped);
      rot.rot_z = clip_to_q16(tz * qw - tw * qz - tx * qy + ty * qx, clipped);
      rot.saturated = clipped;
      return rot;
   endfunction

   // Mostly moderate values so results stay in range, with corners and full-range noise
   function automatic logic [31:0] random_component(input bit is_quat);
      logic [31:0] corner [7] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                  32'h40000000, 32'hC0000000};
      case ($urandom_range(9)) inside
         0: begin
            return corner[$urandom_range(6)];
         end
         [1:2]: begin
            return $urandom;
         end
         default: begin
            if (is_quat)
               return 32'($urandom_range(32'h7FFFFFFF)) - 32'h40000000;
            return 32'($urandom_range(32'h01FFFFFF)) - 32'h01000000;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t, rotation %0d: %s", $realtime, rotations_checked, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, want %h", name, got, want));
   endtask

   // Offer one item from a falling edge; returns at the falling edge after acceptance
   task automatic send_rotation(input quat_type q, input vec_type v, input logic typed,
                                input rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.quat_w <= q.w;
      req_ch.quat_x <= q.x;
      req_ch.quat_y <= q.y;
      req_ch.quat_z <= q.z;
      req_ch.vec_x  <= v.x;
      req_ch.vec_y  <= v.y;
      req_ch.vec_z  <= v.z;
      do
         @(posedge clock);
      while (!req_ch.ready);
      pending_rotations.push_back(typed ? want : rotate_by_quaternion(q, v));
      @(negedge clock);
   endtask

   task automatic send_random_rotations(input int count);
      quat_type q;
      vec_type  v;
      for (int i = 0; i < count; i++) begin
         q.w = random_component(1'b1);
         q.x = random_component(1'b1);
         q.y = random_component(1'b1);
         q.z = random_component(1'b1);
         v.x = random_component(1'b0);
         v.y = random_component(1'b0);
         v.z = random_component(1'b0);
         send_rotation(q, v, 1'b0, '0);
         // long receiver hold-off while items keep coming
         if (i == count / 3 && sender_idle_pct < 40)
            holdoff_wanted = 1'b1;
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random back-pressure, and one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_wanted) begin
            holdoff_wanted = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rotations_checked++;
         if (pending_rotations.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_rotations.pop_front();
            check_field("rot_x", rsp_ch.rot_x, want.rot_x);
            check_field("rot_y", rsp_ch.rot_y, want.rot_y);
            check_field("rot_z", rsp_ch.rot_z, want.rot_z);
            check_field("saturated", {31'b0, rsp_ch.saturated}, {31'b0, want.saturated});
         end
      end
   end

   // Watchdog: too long without any item moving
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("quaternion_vector_rotate: mismatch");
      $finish;
   end

   // Stimulus
   initial begin
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.quat_w = '0;
      req_ch.quat_x = '0;
      req_ch.quat_y = '0;
      req_ch.quat_z = '0;
      req_ch.vec_x  = '0;
      req_ch.vec_y  = '0;
      req_ch.vec_z  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles more lightly than the receiver
      sender_idle_pct   = 29;
      receiver_idle_pct = 46;
      foreach (directed_rows[i])
         send_rotation(directed_rows[i].quat, directed_rows[i].vec,
                       directed_rows[i].typed, directed_rows[i].want);
      send_random_rotations(270);

      // pause until the pipeline has drained
      req_ch.valid <= 1'b0;
      while (pending_rotations.size() != 0)
         @(negedge clock);

      sender_idle_pct   = 46;
      receiver_idle_pct = 29;
      send_random_rotations(270);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      send_random_rotations(260);
      req_ch.valid <= 1'b0;

      while (pending_rotations.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("quaternion_vector_rotate: match");
      else
         $display("quaternion_vector_rotate: mismatch");
      $finish;
   end

endmodule
